>>> src/usc_pkg.sv
// Package with the transfer types and character codes of the URI syntax checker.
`timescale 1ns / 1ps

package usc_pkg;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last;
   } req_type;

   typedef struct packed {
      logic valid_res;
      logic has_scheme;
      logic has_authority;
   } rsp_type;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_COLON   = 8'h3a;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_SEMI    = 8'h3b;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_QUEST   = 8'h3f;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_AT      = 8'h40;

endpackage

>>> src/uri_syntax_checker.sv
// Top level of the URI syntax checker: phase machines between an input and a result register.
// The URI reference enters one byte per transfer on the req_ channel, with last set on
// its final byte. Each byte is captured in an input register, and the phase machines
// update their state from it with a short path of logic. The final byte
// of a URI writes one transfer into the result register on the rsp_ channel: valid_res,
// has_scheme and has_authority. All other bytes give no result.
// Throughput is one byte per cycle while req_stall is low; bytes after a final byte may follow at once.
// The input register passes bytes that are not final even while a result waits on a
// stalled rsp_ channel. A final byte waits in the input register until the result
// register is free, and req_stall is raised behind it for that time.
// A synchronous reset empties both registers and returns the phase machines to the
// start of a URI. After each final byte the state also returns to the start.
`timescale 1ns / 1ps

module uri_syntax_checker
   import usc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      PH_START, PH_SCHEME, PH_COLON, PH_SLASH, PH_AUTH,
      PH_OPAQUE, PH_SEG, PH_PARAM, PH_QUERY
   } phase_type;

   typedef enum logic [2:0] {
      NS_REL, NS_SEG, NS_PARAM, NS_QUERY, NS_FAIL
   } ns_phase_type;

   typedef enum logic [1:0] {
      TL_SEG, TL_PARAM, TL_QUERY
   } tail_type;

   typedef struct packed {
      logic     ok;
      tail_type tail;
   } tail_res_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_alpha(c) || is_digit(c);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_mark(input logic [7:0] c);
      return c == CH_MINUS || c == 8'h5f || c == CH_DOT || c == 8'h21 || c == 8'h7e ||
             c == 8'h2a || c == 8'h27 || c == 8'h28 || c == 8'h29;
   endfunction

   function automatic logic is_part_res(input logic [7:0] c);
      return c == 8'h26 || c == 8'h3d || c == CH_PLUS || c == 8'h24 || c == 8'h2c;
   endfunction

   function automatic logic is_base(input logic [7:0] c);
      return is_alnum(c) || is_mark(c) || c == CH_PERCENT || is_part_res(c);
   endfunction

   function automatic logic is_uric(input logic [7:0] c);
      return is_base(c) || c == CH_SEMI || c == CH_SLASH || c == CH_QUEST ||
             c == CH_COLON || c == CH_AT || c == CH_HASH;
   endfunction

   function automatic logic is_auth(input logic [7:0] c);
      return is_base(c) || c == CH_SEMI || c == CH_COLON || c == CH_AT;
   endfunction

   function automatic logic is_rel(input logic [7:0] c);
      return is_base(c) || c == CH_SEMI || c == CH_AT;
   endfunction

   function automatic logic is_segc(input logic [7:0] c);
      return is_base(c) || c == CH_COLON || c == CH_AT || c == CH_SLASH;
   endfunction

   function automatic logic is_paramc(input logic [7:0] c);
      return is_base(c) || c == CH_COLON || c == CH_AT || c == CH_SEMI;
   endfunction

   function automatic tail_res_type tail_step(input tail_type t, input logic [7:0] c);
      tail_res_type r;
      r.ok   = 1'b1;
      r.tail = t;
      if (t == TL_QUERY) begin
         r.ok = is_uric(c);
      end else if (c == CH_QUEST || c == CH_HASH) begin
         r.tail = TL_QUERY;
      end else if (t == TL_SEG) begin
         if (c == CH_SEMI) begin
            r.tail = TL_PARAM;
         end else begin
            r.ok = is_segc(c);
         end
      end else if (c == CH_SLASH) begin
         r.tail = TL_SEG;
      end else begin
         r.ok = is_paramc(c);
      end
      return r;
   endfunction

   function automatic phase_type tail_to_phase(input tail_type t);
      phase_type p;
      unique case (t)
         TL_SEG:   p = PH_SEG;
         TL_PARAM: p = PH_PARAM;
         default:  p = PH_QUERY;
      endcase
      return p;
   endfunction

   function automatic ns_phase_type tail_to_ns(input tail_type t);
      ns_phase_type p;
      unique case (t)
         TL_SEG:   p = NS_SEG;
         TL_PARAM: p = NS_PARAM;
         default:  p = NS_QUERY;
      endcase
      return p;
   endfunction

   logic         s1_valid_ff, s1_valid_in;
   req_type      s1_data_ff;
   logic         s1_adv;
   logic         req_accept;

   phase_type    phase_ff, phase_in;
   ns_phase_type ns_phase_ff, ns_phase_in;
   logic         prefix_ok_ff, prefix_ok_in;
   logic [1:0]   pending_ff, pending_in;
   logic         failed_ff, failed_in;
   logic         scheme_ff, scheme_in;
   logic         authority_ff, authority_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic         result_load;

   assign s1_adv     = !s1_data_ff.last || !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign result_load = s1_valid_ff && s1_adv && s1_data_ff.last;

   always_comb begin
      logic [7:0]   c;
      tail_res_type tr;
      phase_type    ph;
      ns_phase_type ns;
      logic         pok;
      logic [1:0]   pend;
      logic         fl;
      logic         ss;
      logic         as;

      c    = s1_data_ff.char_in;
      ph   = phase_ff;
      ns   = ns_phase_ff;
      pok  = prefix_ok_ff;
      pend = pending_ff;
      fl   = failed_ff;
      ss   = scheme_ff;
      as   = authority_ff;
      tr   = tail_step(TL_SEG, c);

      if (pend != 2'd0) begin
         if (!is_hex(c)) fl = 1'b1;
         pend = pend - 2'd1;
      end else begin
         unique case (ph)
            PH_START, PH_SCHEME: begin
               if (c == CH_COLON) begin
                  ss = 1'b1;
                  if (ph == PH_START || !pok) fl = 1'b1;
                  ph = PH_COLON;
               end else begin
                  if (ph == PH_START) begin
                     if (!is_alpha(c)) pok = 1'b0;
                  end else if (!(is_alnum(c) || c == CH_PLUS || c == CH_MINUS ||
                                 c == CH_DOT)) begin
                     pok = 1'b0;
                  end
                  ph = PH_SCHEME;
                  unique case (ns)
                     NS_REL: begin
                        if (c == CH_SLASH) ns = NS_SEG;
                        else if (c == CH_QUEST || c == CH_HASH) ns = NS_QUERY;
                        else if (!is_rel(c)) ns = NS_FAIL;
                     end
                     NS_SEG, NS_PARAM, NS_QUERY: begin
                        tr = tail_step((ns == NS_SEG) ? TL_SEG :
                                       (ns == NS_PARAM) ? TL_PARAM : TL_QUERY, c);
                        ns = tr.ok ? tail_to_ns(tr.tail) : NS_FAIL;
                     end
                     default: ns = NS_FAIL;
                  endcase
               end
            end
            PH_COLON: begin
               if (c == CH_SLASH) begin
                  ph = PH_SLASH;
               end else begin
                  if (!(is_auth(c) || c == CH_QUEST)) fl = 1'b1;
                  ph = PH_OPAQUE;
               end
            end
            PH_SLASH: begin
               if (c == CH_SLASH) begin
                  ph = PH_AUTH;
                  as = 1'b1;
               end else begin
                  tr = tail_step(TL_SEG, c);
                  ph = tail_to_phase(tr.tail);
                  if (!tr.ok) fl = 1'b1;
               end
            end
            PH_AUTH: begin
               if (c == CH_SLASH) ph = PH_SEG;
               else if (!is_auth(c)) fl = 1'b1;
            end
            PH_OPAQUE: begin
               if (c == CH_HASH) ph = PH_QUERY;
               else if (!is_uric(c)) fl = 1'b1;
            end
            PH_SEG, PH_PARAM, PH_QUERY: begin
               tr = tail_step((ph == PH_SEG) ? TL_SEG :
                              (ph == PH_PARAM) ? TL_PARAM : TL_QUERY, c);
               ph = tail_to_phase(tr.tail);
               if (!tr.ok) fl = 1'b1;
            end
            default: fl = 1'b1;
         endcase
         if (c == CH_PERCENT) pend = 2'd2;
      end

      if (ph == PH_START || ph == PH_SCHEME) begin
         rsp_data_in.valid_res = !fl && pend == 2'd0 && ns != NS_FAIL;
      end else begin
         rsp_data_in.valid_res = !fl && pend == 2'd0 && ph != PH_COLON;
      end
      rsp_data_in.has_scheme    = ss;
      rsp_data_in.has_authority = as;

      if (s1_data_ff.last) begin
         phase_in     = PH_START;
         ns_phase_in  = NS_REL;
         prefix_ok_in = 1'b1;
         pending_in   = 2'd0;
         failed_in    = 1'b0;
         scheme_in    = 1'b0;
         authority_in = 1'b0;
      end else begin
         phase_in     = ph;
         ns_phase_in  = ns;
         prefix_ok_in = pok;
         pending_in   = pend;
         failed_in    = fl;
         scheme_in    = ss;
         authority_in = as;
      end
   end

   assign rsp_valid_in = result_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         ns_phase_ff  <= NS_REL;
         prefix_ok_ff <= 1'b1;
         pending_ff   <= 2'd0;
         failed_ff    <= 1'b0;
         scheme_ff    <= 1'b0;
         authority_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && s1_adv) begin
            phase_ff     <= phase_in;
            ns_phase_ff  <= ns_phase_in;
            prefix_ok_ff <= prefix_ok_in;
            pending_ff   <= pending_in;
            failed_ff    <= failed_in;
            scheme_ff    <= scheme_in;
            authority_ff <= authority_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) s1_data_ff <= req_data;
      if (result_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/usc_checker.sv
// Port checker for the URI syntax checker and the bind that attaches it.
`timescale 1ns / 1ps

module usc_checker
   import usc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A reset leaves no result transfer pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A stalled request stays offered and unchanged.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // An authority part can only follow a scheme colon.
   a_auth_needs_scheme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.has_authority || rsp_data.has_scheme))
      else $error("authority reported without scheme");

   // The input side is only held back by a result waiting on a stalled output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output free");

endmodule

bind uri_syntax_checker usc_checker u_usc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
